// File: design/uid_access_table_assert.svh
// Assertion macros used by the uid access table checker.
`ifndef UID_ACCESS_TABLE_ASSERT_SVH
`define UID_ACCESS_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UAT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uid_access_table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define UAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uid_access_table assertion failed");

`endif

// File: design/uat_pkg.sv
// Shared types and constants of the uid access table.
package uat_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int ID_BYTES_DEF = 4;
  localparam int ID_W         = 32;
  localparam int CNT_OUT_W    = 5;

  localparam logic [ID_W-1:0] DEF_ID0 = 32'h11223344;
  localparam logic [ID_W-1:0] DEF_ID1 = 32'hAABBCCDD;

  typedef enum logic [1:0] {
    CMD_ADD        = 2'd0,
    CMD_REMOVE     = 2'd1,
    CMD_CHECK      = 2'd2,
    CMD_SET_ENABLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] card_id;
    logic            enable_value;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic                 enabled;
    logic [CNT_OUT_W-1:0] entry_count;
  } resp_t;

endpackage

// File: design/uat_in_if.sv
// Command channel of the uid access table.
interface uat_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [uat_pkg::ID_W-1:0] card_id;
  logic                     enable_value;

  modport source (output valid, cmd, card_id, enable_value, input ready);
  modport sink   (input valid, cmd, card_id, enable_value, output ready);
endinterface

// File: design/uat_out_if.sv
// Result channel of the uid access table.
interface uat_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          enabled;
  logic [uat_pkg::CNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, enabled, entry_count, input ready);
  modport sink   (input valid, status, enabled, entry_count, output ready);
endinterface

// File: design/uat_mem.sv
// Entry memory: one write and one registered read port, default entries overlaid.
module uat_mem #(
  parameter int ENTRIES  = uat_pkg::ENTRIES_DEF,
  parameter int ID_BYTES = uat_pkg::ID_BYTES_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         we,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] waddr,
  input  logic [((ID_BYTES*8 > 32) ? 32 : ID_BYTES*8):0] wdata,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] raddr,
  output logic [((ID_BYTES*8 > 32) ? 32 : ID_BYTES*8):0] rdata
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW = (ID_BYTES*8 > 32) ? 32 : ID_BYTES*8;
  localparam int WW = KW + 1;

  localparam logic [WW-1:0] DEF_WORD0 = {1'b1, uat_pkg::DEF_ID0[KW-1:0]};
  localparam logic [WW-1:0] DEF_WORD1 = {1'b1, uat_pkg::DEF_ID1[KW-1:0]};

  logic [WW-1:0] mem [ENTRIES];
  logic [WW-1:0] rdata_r;
  logic [IW-1:0] raddr_r;
  logic [1:0]    written_r;
  logic [1:0]    written_nxt;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
    raddr_r <= raddr;
  end

  always_comb begin
    written_nxt = written_r;
    if (we && waddr == IW'(0)) begin
      written_nxt[0] = 1'b1;
    end
    if (we && waddr == IW'(1)) begin
      written_nxt[1] = 1'b1;
    end
  end

  // Entries 0 and 1 read as the default ids until first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= 2'b00;
    end else begin
      written_r <= written_nxt;
    end
  end

  always_comb begin
    if (raddr_r == IW'(0) && !written_r[0]) begin
      rdata = DEF_WORD0;
    end else if (raddr_r == IW'(1) && !written_r[1]) begin
      rdata = DEF_WORD1;
    end else begin
      rdata = rdata_r;
    end
  end

endmodule

// File: design/uat_ctrl.sv
// Command sequencer: scans the entry memory, then edits it in place.
module uat_ctrl #(
  parameter int ENTRIES  = uat_pkg::ENTRIES_DEF,
  parameter int ID_BYTES = uat_pkg::ID_BYTES_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           req_valid,
  output logic                                           req_ready,
  input  uat_pkg::req_t                                  req,
  output logic                                           resp_valid,
  input  logic                                           resp_ready,
  output uat_pkg::resp_t                                 resp,
  output logic                                           mem_we,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] mem_waddr,
  output logic [((ID_BYTES*8 > 32) ? 32 : ID_BYTES*8):0] mem_wdata,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] mem_raddr,
  input  logic [((ID_BYTES*8 > 32) ? 32 : ID_BYTES*8):0] mem_rdata
);

  localparam int IW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW       = (ID_BYTES*8 > 32) ? 32 : ID_BYTES*8;
  localparam int CW       = $clog2(ENTRIES + 1);
  localparam int INIT_CNT = (ENTRIES >= 2) ? 2 : 1;

  uat_pkg::state_t  state_r, state_nxt;
  uat_pkg::cmd_t    cmd_r, cmd_nxt;
  uat_pkg::status_t status_r, status_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic             en_r, en_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic             pend_r, pend_nxt;
  logic [IW-1:0]    pidx_r, pidx_nxt;
  logic             hit_r, hit_nxt;
  logic [IW-1:0]    hidx_r, hidx_nxt;
  logic             hflag_r, hflag_nxt;
  logic             flag_r, flag_nxt;
  logic             match;
  logic             full;
  logic [CW+uat_pkg::CNT_OUT_W-1:0] count_ext;

  assign match     = pend_r && (mem_rdata[KW-1:0] == key_r);
  assign full      = (count_r == CW'(ENTRIES));
  assign count_ext = {{uat_pkg::CNT_OUT_W{1'b0}}, count_r};

  assign resp.status      = status_r;
  assign resp.enabled     = flag_r;
  assign resp.entry_count = count_ext[uat_pkg::CNT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uat_pkg::S_IDLE;
      count_r <= CW'(INIT_CNT);
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    key_r    <= key_nxt;
    en_r     <= en_nxt;
    ptr_r    <= ptr_nxt;
    pidx_r   <= pidx_nxt;
    hit_r    <= hit_nxt;
    hidx_r   <= hidx_nxt;
    hflag_r  <= hflag_nxt;
    flag_r   <= flag_nxt;
  end

  // No write is in flight while a scan reads, and shift writes trail their
  // reads by one entry, so the memory needs no forwarding.
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    key_nxt    = key_r;
    en_nxt     = en_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    hit_nxt    = hit_r;
    hidx_nxt   = hidx_r;
    hflag_nxt  = hflag_r;
    flag_nxt   = flag_r;
    req_ready  = 1'b0;
    resp_valid = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = ptr_r[IW-1:0];

    case (state_r)
      uat_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd_nxt   = req.cmd;
          key_nxt   = req.card_id[KW-1:0];
          en_nxt    = req.enable_value;
          ptr_nxt   = '0;
          pend_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          state_nxt = uat_pkg::S_SCAN;
        end
      end

      uat_pkg::S_SCAN: begin
        if (match) begin
          hit_nxt   = 1'b1;
          hidx_nxt  = pidx_r;
          hflag_nxt = mem_rdata[KW];
          pend_nxt  = 1'b0;
          state_nxt = uat_pkg::S_ACT;
        end else if (ptr_r < count_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = ptr_r[IW-1:0];
          ptr_nxt  = ptr_r + CW'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = uat_pkg::S_ACT;
        end
      end

      uat_pkg::S_ACT: begin
        flag_nxt  = 1'b0;
        state_nxt = uat_pkg::S_RESP;
        case (cmd_r)
          uat_pkg::CMD_ADD: begin
            if (full) begin
              status_nxt = uat_pkg::ST_FULL;
            end else if (hit_r) begin
              status_nxt = uat_pkg::ST_PRESENT;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count_r[IW-1:0];
              mem_wdata  = {1'b1, key_r};
              count_nxt  = count_r + CW'(1);
              status_nxt = uat_pkg::ST_DONE;
            end
          end
          uat_pkg::CMD_REMOVE: begin
            if (hit_r) begin
              status_nxt = uat_pkg::ST_DONE;
              ptr_nxt    = CW'(hidx_r) + CW'(1);
              pend_nxt   = 1'b0;
              state_nxt  = uat_pkg::S_SHIFT;
            end else begin
              status_nxt = uat_pkg::ST_NOT_FOUND;
            end
          end
          uat_pkg::CMD_CHECK: begin
            if (hit_r) begin
              flag_nxt   = hflag_r;
              status_nxt = uat_pkg::ST_DONE;
            end else begin
              status_nxt = uat_pkg::ST_NOT_FOUND;
            end
          end
          uat_pkg::CMD_SET_ENABLE: begin
            if (hit_r) begin
              mem_we     = 1'b1;
              mem_waddr  = hidx_r;
              mem_wdata  = {en_r, key_r};
              status_nxt = uat_pkg::ST_DONE;
            end else begin
              status_nxt = uat_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            status_nxt = uat_pkg::ST_NOT_FOUND;
          end
        endcase
      end

      uat_pkg::S_SHIFT: begin
        // Move each later entry down one place: write the beat read last cycle.
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_r - IW'(1);
          mem_wdata = mem_rdata;
        end
        if (ptr_r < count_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = ptr_r[IW-1:0];
          ptr_nxt  = ptr_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = uat_pkg::S_RESP;
          end
        end
      end

      uat_pkg::S_RESP: begin
        resp_valid = 1'b1;
        if (resp_ready) begin
          state_nxt = uat_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = uat_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: design/uid_access_table.sv
// Top level of the uid access table: sequencer, entry memory, result register.
//
// Holds up to ENTRIES card ids, each with an enable flag, packed in add order.
// in_if carries one command beat (cmd, card_id, enable_value); out_if returns
// one result beat (status, enabled, entry_count) for every command.
// Commands are taken one at a time. The sequencer reads the entry memory one
// entry a cycle through its single read port and compares each entry to the
// key; a match ends the scan early. A remove then moves the entries after the
// match down, one per cycle.
// A new command is accepted only in the idle state that follows the transfer
// of the previous result into the output register.
// Edits are written back after the scan ends, so scans and writes never touch
// the same entry in the same cycle.
// The result sits in an output register: while the receiver stalls, the next
// command can still be accepted and scanned; only its result waits.
// Reset (rst_n low, synchronous) empties the output, returns to idle and
// leaves two default ids, 0x11223344 and 0xAABBCCDD, both enabled (only the
// first when ENTRIES is 1).
module uid_access_table #(
  parameter int ENTRIES  = uat_pkg::ENTRIES_DEF,
  parameter int ID_BYTES = uat_pkg::ID_BYTES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  uat_in_if.sink   in_if,
  uat_out_if.source out_if
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW = (ID_BYTES*8 > 32) ? 32 : ID_BYTES*8;

  uat_pkg::req_t  req;
  uat_pkg::resp_t resp;
  uat_pkg::resp_t out_r;
  logic           out_valid_r;
  logic           resp_valid;
  logic           resp_ready;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  logic [KW:0]    mem_wdata;
  logic [IW-1:0]  mem_raddr;
  logic [KW:0]    mem_rdata;

  assign req.cmd          = uat_pkg::cmd_t'(in_if.cmd);
  assign req.card_id      = in_if.card_id;
  assign req.enable_value = in_if.enable_value;

  uat_ctrl #(.ENTRIES(ENTRIES), .ID_BYTES(ID_BYTES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_if.valid),
    .req_ready  (in_if.ready),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  uat_mem #(.ENTRIES(ENTRIES), .ID_BYTES(ID_BYTES)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign resp_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_r <= resp;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_r.status;
  assign out_if.enabled     = out_r.enabled;
  assign out_if.entry_count = out_r.entry_count;

endmodule

// File: design/uat_checker.sv
// Port-level assertions for the uid access table, bound to the top level.
`include "uid_access_table_assert.svh"

module uat_checker #(
  parameter int ENTRIES = uat_pkg::ENTRIES_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic                          out_enabled,
  input logic [uat_pkg::CNT_OUT_W-1:0] out_entry_count
);

  `UAT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `UAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_enabled) && $stable(out_entry_count))
  `UAT_ASSERT_SAME(a_flag_only_on_done, out_valid && out_enabled, out_status == uat_pkg::ST_DONE)
  `UAT_ASSERT_SAME(a_full_count, out_valid && out_status == uat_pkg::ST_FULL && ENTRIES < 32, out_entry_count == uat_pkg::CNT_OUT_W'(ENTRIES))

endmodule

bind uid_access_table uat_checker #(.ENTRIES(ENTRIES)) u_uat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_enabled     (out_if.enabled),
  .out_entry_count (out_if.entry_count)
);
